/* design/itl_pkg.sv */
// Shared types and constants of the interval table lookup block.
package itl_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int PTR_W       = IDX_W + 2;
   localparam int KEY_W       = 17;
   localparam int SPAN_W      = 6;
   localparam int CODE_W      = 9;

   localparam logic [CODE_W-1:0] MISS_CODE = 9'h1FF;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_WRITE  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [SPAN_W-1:0] span;
      logic [KEY_W-1:0]  start;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } tbl_rd_type;

endpackage

/* design/itl_channels.sv */
// Handshake channel interfaces of the interval table lookup block.
interface itl_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [itl_pkg::KEY_W-1:0]  key;
   logic [itl_pkg::IDX_W-1:0]  entry_index;
   logic [itl_pkg::KEY_W-1:0]  entry_start;
   logic [itl_pkg::SPAN_W-1:0] entry_span;
   logic [itl_pkg::CODE_W-1:0] entry_code;

   modport source (output valid, opcode, key, entry_index, entry_start, entry_span,
                   entry_code, input ready);
   modport sink (input valid, opcode, key, entry_index, entry_start, entry_span,
                 entry_code, output ready);
endinterface

interface itl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [itl_pkg::CODE_W-1:0] code;
   logic                       hit;

   modport source (output valid, code, hit, input ready);
   modport sink (input valid, code, hit, output ready);
endinterface

interface itl_csr_if;
   logic                      valid;
   logic                      ready;
   logic [itl_pkg::CNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* design/itl_table.sv */
// Interval entry memory: one write port, one registered read port.
module itl_table (
   input  logic                clock,
   input  itl_pkg::tbl_wr_type wr,
   input  itl_pkg::tbl_rd_type rd,
   output itl_pkg::entry_type  rdata
);

   itl_pkg::entry_type mem_ff [itl_pkg::TABLE_DEPTH];
   itl_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rdata_ff <= mem_ff[rd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/itl_search.sv */
// Binary search sequencer with shared interval compare and result register.
module itl_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [itl_pkg::CNT_W-1:0] entry_count,
   itl_req_if.sink                   req,
   itl_rsp_if.source                 rsp,
   output itl_pkg::tbl_wr_type       wr,
   output itl_pkg::tbl_rd_type       rd,
   input  itl_pkg::entry_type        rdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic signed [itl_pkg::PTR_W-1:0] left_ff, left_in;
   logic signed [itl_pkg::PTR_W-1:0] right_ff, right_in;
   logic [itl_pkg::IDX_W-1:0]        mid_ff, mid_in;
   logic [itl_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [itl_pkg::CODE_W-1:0]       res_code_ff, res_code_in;
   logic                             res_hit_ff, res_hit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [itl_pkg::CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic                             rsp_hit_ff, rsp_hit_in;

   logic [itl_pkg::CNT_W-1:0]        count_clamped;
   logic [itl_pkg::PTR_W:0]          ptr_sum;
   logic [itl_pkg::IDX_W-1:0]        mid;
   logic [itl_pkg::KEY_W:0]          last;
   logic                             covered;
   logic                             req_fire;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign count_clamped = (entry_count > itl_pkg::CNT_W'(itl_pkg::TABLE_DEPTH))
                        ? itl_pkg::CNT_W'(itl_pkg::TABLE_DEPTH) : entry_count;
   assign ptr_sum = {left_ff[itl_pkg::PTR_W-1], left_ff}
                  + {right_ff[itl_pkg::PTR_W-1], right_ff};
   assign mid     = ptr_sum[itl_pkg::IDX_W:1];
   assign last    = {1'b0, rdata.start} + {{(itl_pkg::KEY_W+1-itl_pkg::SPAN_W){1'b0}},
                                           rdata.span};
   assign covered = ({1'b0, rdata.start} <= {1'b0, key_ff}) && ({1'b0, key_ff} <= last);

   always_comb begin
      wr.en   = req_fire && (req.opcode == itl_pkg::OP_WRITE);
      wr.addr = req.entry_index;
      wr.data = '{code: req.entry_code, span: req.entry_span, start: req.entry_start};
      rd.en   = (state_ff == ST_PROBE);
      rd.addr = mid;
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_code_in  = res_code_ff;
      res_hit_in   = res_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_hit_in   = rsp_hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req.opcode == itl_pkg::OP_LOOKUP)) begin
               key_in   = req.key;
               left_in  = '0;
               right_in = $signed({1'b0, count_clamped}) - itl_pkg::PTR_W'(1);
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (left_ff > right_ff) begin
               res_code_in = itl_pkg::MISS_CODE;
               res_hit_in  = 1'b0;
               state_in    = ST_FINISH;
            end else begin
               mid_in   = mid;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (covered) begin
               res_code_in = rdata.code;
               res_hit_in  = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               if ({1'b0, key_ff} > last) begin
                  left_in = $signed({2'b00, mid_ff}) + itl_pkg::PTR_W'(1);
               end else begin
                  right_in = $signed({2'b00, mid_ff}) - itl_pkg::PTR_W'(1);
               end
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff     <= left_in;
      right_ff    <= right_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      res_code_ff <= res_code_in;
      res_hit_ff  <= res_hit_in;
      rsp_code_ff <= rsp_code_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.code  = rsp_code_ff;
   assign rsp.hit   = rsp_hit_ff;

endmodule

/* design/interval_table_lookup.sv */
// Top level of the interval table lookup block.
// A write word stores one entry and returns nothing. A lookup word runs a binary
// search over the first entry_count entries (capped at the table depth). Each
// probe is a registered memory read followed by an interval compare. A lookup
// makes at most 11 probes for a full table of 1024 entries. Its result waits in
// the finish state while an earlier result still waits to be taken. The single
// read port of the entry memory makes the probes run one after another. The
// request side is ready again as soon as the result is loaded into the output
// register, even if that result is still waiting to be taken. The entry memory
// has no reset; entry_count resets to zero and is written through the csr port.
module interval_table_lookup (
   input  logic      clock,
   input  logic      reset,
   itl_req_if.sink   req_ch,
   itl_rsp_if.source rsp_ch,
   itl_csr_if.sink   csr_ch
);

   logic [itl_pkg::CNT_W-1:0] entry_count_ff, entry_count_in;
   itl_pkg::tbl_wr_type       tbl_wr;
   itl_pkg::tbl_rd_type       tbl_rd;
   itl_pkg::entry_type        tbl_rdata;

   assign csr_ch.ready   = 1'b1;
   assign entry_count_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   itl_table u_table (
      .clock (clock),
      .wr    (tbl_wr),
      .rd    (tbl_rd),
      .rdata (tbl_rdata)
   );

   itl_search u_search (
      .clock       (clock),
      .reset       (reset),
      .entry_count (entry_count_ff),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .wr          (tbl_wr),
      .rd          (tbl_rd),
      .rdata       (tbl_rdata)
   );

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.opcode == itl_pkg::OP_LOOKUP))
      |=> !req_ch.ready)
      else $error("request side ready right after a lookup was taken");

   a_write_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.opcode == itl_pkg::OP_WRITE))
      |=> req_ch.ready)
      else $error("entry write did not complete in one cycle");

   a_result_after_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result appeared without a search in progress");

   a_count_written: assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.ready) |=> (entry_count_ff == $past(csr_ch.data)))
      else $error("entry count did not take the written word");

endmodule

/* tb/tb_interval_table_lookup.sv */
`timescale 1ns / 1ps
// Self-checking testbench for interval_table_lookup: random table words and lookups.
module tb_interval_table_lookup;

   localparam int WATCH_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 30;
   localparam int SLOT          = 128;
   localparam int KEY_MAX       = (1 << itl_pkg::KEY_W) - 1;

   typedef struct {
      itl_pkg::opcode_type       op;
      logic [itl_pkg::KEY_W-1:0] key;
      logic [itl_pkg::IDX_W-1:0] index;
      itl_pkg::entry_type        ent;
   } req_word_type;

   typedef struct {
      logic [itl_pkg::CODE_W-1:0] code;
      logic                       hit;
   } lookup_result_type;

   logic clock;
   logic reset;
   logic quiet = 1'b0;
   int   error_count = 0;
   int   idle_cycles = 0;

   req_word_type       pending_words[$];
   lookup_result_type  expected_results[$];
   itl_pkg::entry_type model_table[itl_pkg::TABLE_DEPTH];
   int unsigned        model_count = 0;
   itl_pkg::entry_type plan_table[itl_pkg::TABLE_DEPTH];
   int unsigned        plan_count = 0;

   itl_req_if req_ch();
   itl_rsp_if rsp_ch();
   itl_csr_if csr_ch();

   interval_table_lookup u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic lookup_result_type search_intervals(
      input logic [itl_pkg::KEY_W-1:0] key);
      int                      lo;
      int                      hi;
      int                      mid;
      logic [itl_pkg::KEY_W:0] last;
      itl_pkg::entry_type      e;
      lookup_result_type       r;
      lo     = 0;
      hi     = ((model_count > itl_pkg::TABLE_DEPTH) ? itl_pkg::TABLE_DEPTH
                                                      : int'(model_count)) - 1;
      r.code = itl_pkg::MISS_CODE;
      r.hit  = 1'b0;
      while (lo <= hi) begin
         mid  = (lo + hi) / 2;
         e    = model_table[mid];
         last = {1'b0, e.start} + {{(itl_pkg::KEY_W+1-itl_pkg::SPAN_W){1'b0}}, e.span};
         if ({1'b0, key} >= {1'b0, e.start} && {1'b0, key} <= last) begin
            r.code = e.code;
            r.hit  = 1'b1;
            return r;
         end
         if ({1'b0, key} > last) lo = mid + 1;
         else hi = mid - 1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      req_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
            w = pending_words.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.opcode      <= w.op;
            req_ch.key         <= w.key;
            req_ch.entry_index <= w.index;
            req_ch.entry_start <= w.ent.start;
            req_ch.entry_span  <= w.ent.span;
            req_ch.entry_code  <= w.ent.code;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (quiet) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 99) >= 26);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) model_count = 32'(csr_ch.data);
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.opcode == itl_pkg::OP_WRITE)
               model_table[req_ch.entry_index] =
                  {req_ch.entry_code, req_ch.entry_span, req_ch.entry_start};
            else
               expected_results.push_back(search_intervals(req_ch.key));
         end
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result with none expected, actual code=%0d hit=%0b",
                     $time, rsp_ch.code, rsp_ch.hit);
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.code !== want.code) begin
               error_count++;
               $display("%0t: code mismatch, expected %0d actual %0d",
                        $time, want.code, rsp_ch.code);
            end
            if (rsp_ch.hit !== want.hit) begin
               error_count++;
               $display("%0t: hit mismatch, expected %0b actual %0b",
                        $time, want.hit, rsp_ch.hit);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_write(input int unsigned index, input int unsigned start,
                             input int unsigned span, input int unsigned code);
      req_word_type w;
      w.op        = itl_pkg::OP_WRITE;
      w.key       = itl_pkg::KEY_W'($urandom_range(0, KEY_MAX));
      w.index     = itl_pkg::IDX_W'(index);
      w.ent.start = itl_pkg::KEY_W'(start);
      w.ent.span  = itl_pkg::SPAN_W'(span);
      w.ent.code  = itl_pkg::CODE_W'(code);
      plan_table[w.index] = w.ent;
      pending_words.push_back(w);
   endtask

   task automatic push_lookup(input int unsigned key);
      req_word_type w;
      w.op        = itl_pkg::OP_LOOKUP;
      w.key       = itl_pkg::KEY_W'(key);
      w.index     = itl_pkg::IDX_W'($urandom_range(0, itl_pkg::TABLE_DEPTH - 1));
      w.ent.start = itl_pkg::KEY_W'($urandom_range(0, KEY_MAX));
      w.ent.span  = itl_pkg::SPAN_W'($urandom_range(0, (1 << itl_pkg::SPAN_W) - 1));
      w.ent.code  = itl_pkg::CODE_W'($urandom_range(0, (1 << itl_pkg::CODE_W) - 1));
      pending_words.push_back(w);
   endtask

   // keep each entry inside its own slot so the table stays sorted
   task automatic push_slot_write(input int unsigned index);
      push_write(index, index * SLOT + $urandom_range(0, SLOT / 2),
                 $urandom_range(0, (1 << itl_pkg::SPAN_W) - 1),
                 $urandom_range(0, (1 << itl_pkg::CODE_W) - 1));
   endtask

   function automatic int unsigned pick_key();
      int unsigned        n;
      int unsigned        lo;
      int unsigned        hi;
      int unsigned        k;
      itl_pkg::entry_type e;
      n = (plan_count > itl_pkg::TABLE_DEPTH) ? itl_pkg::TABLE_DEPTH : plan_count;
      if (n == 0 || $urandom_range(0, 9) < 2) return $urandom_range(0, KEY_MAX);
      e  = plan_table[$urandom_range(0, n - 1)];
      lo = 32'(e.start);
      hi = lo + 32'(e.span);
      case ($urandom_range(0, 7))
         0: return (lo == 0) ? 0 : lo - 1;
         1: return (hi >= KEY_MAX) ? KEY_MAX : hi + 1;
         default: begin
            k = $urandom_range(lo, hi);
            return (k > KEY_MAX) ? KEY_MAX : k;
         end
      endcase
   endfunction

   task automatic push_random(input int count);
      int unsigned sel;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 8)
            push_slot_write($urandom_range(0, itl_pkg::TABLE_DEPTH - 1));
         else if (sel < 11)
            push_write($urandom_range(0, itl_pkg::TABLE_DEPTH - 1),
                       $urandom_range(0, KEY_MAX),
                       $urandom_range(0, (1 << itl_pkg::SPAN_W) - 1),
                       $urandom_range(0, (1 << itl_pkg::CODE_W) - 1));
         else
            push_lookup(pick_key());
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_ch.valid || expected_results.size() != 0);
   endtask

   task automatic set_count(input int unsigned value);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value[itl_pkg::CNT_W-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      plan_count = value;
   endtask

   initial begin
      int unsigned phase_counts[10];
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = itl_pkg::OP_LOOKUP;
      req_ch.key         = '0;
      req_ch.entry_index = '0;
      req_ch.entry_start = '0;
      req_ch.entry_span  = '0;
      req_ch.entry_code  = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table after reset: every lookup misses
      push_lookup(0);
      push_lookup(KEY_MAX);
      push_write(0, 0, 0, 0);
      push_write(1, 100, 63, itl_pkg::MISS_CODE);
      push_write(2, 1000, 10, 9'h155);
      push_write(3, KEY_MAX, 63, 9'h0AA);
      set_count(4);
      push_lookup(0);
      push_lookup(1);
      push_lookup(100);
      push_lookup(163);
      push_lookup(164);
      push_lookup(1005);
      push_lookup(KEY_MAX - 1);
      push_lookup(KEY_MAX);
      // break the order: the covering entry is never probed
      push_write(2, 50, 0, 9'h0F0);
      push_lookup(50);

      for (int i = itl_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
         push_slot_write(i);
         if (i % 16 == 0) push_lookup($urandom_range(0, KEY_MAX));
      end

      phase_counts = '{1024, 2047, 1, 2, 3, 0, 1023, 0, 0, 1024};
      phase_counts[7] = $urandom_range(4, itl_pkg::TABLE_DEPTH);
      phase_counts[8] = $urandom_range(4, 40);
      foreach (phase_counts[p]) begin
         set_count(phase_counts[p]);
         quiet = (p == 6);
         push_random(28);
         drain();
         push_random(28);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
